FILE: rtl/rgb_led_fade_engine_defines.svh
// Assertion macros shared by the checker.
`ifndef RGB_LED_FADE_ENGINE_DEFINES_SVH
`define RGB_LED_FADE_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define FDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fde_pkg.sv
package fde_pkg;

    localparam int COLOR_W   = 8;
    localparam int DUR_W     = 15;
    localparam int EL_W      = 16;
    localparam int SPD_QW    = 12;
    localparam int DUR_SHIFT = 3;
    localparam int ACC_W     = 23;

    localparam logic [SPD_QW-1:0] SPD_NUM = 12'd4095;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPD,
        S_APPLY,
        S_LOAD,
        S_LERP,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic               go;
        logic [COLOR_W-1:0] s;
        logic [COLOR_W-1:0] t;
        logic [EL_W-1:0]    el;
        logic [DUR_W-1:0]   dur;
    } lerp_req_t;

endpackage

FILE: rtl/fde_spd.sv
module fde_spd
    import fde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [7:0]        speed,
    output logic [SPD_QW-1:0] quot,
    output logic              done
);

    logic              busy_reg, busy_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [SPD_QW-1:0] num_reg, num_next;
    logic [7:0]        rem_reg, rem_next;
    logic [SPD_QW-1:0] q_reg, q_next;
    logic [8:0]        trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        trial     = {rem_reg, num_reg[SPD_QW-1]};
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = SPD_NUM;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, speed})
            begin
                rem_next = 8'(trial - {1'b0, speed});
                q_next   = {q_reg[SPD_QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                q_next   = {q_reg[SPD_QW-2:0], 1'b0};
            end
            num_next = {num_reg[SPD_QW-2:0], 1'b0};
            cnt_next = 4'(cnt_reg + 1'b1);
            if (cnt_reg == 4'(SPD_QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

FILE: rtl/fde_lerp.sv
// One color channel: bit-serial s*(dur-el) + t*el, then bit-serial divide by dur.
module fde_lerp
    import fde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lerp_req_t          req,
    output logic [COLOR_W-1:0] quot,
    output logic               done
);

    logic               busy_reg, busy_next;
    logic               div_reg, div_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [COLOR_W-1:0] s_reg, s_next;
    logic [COLOR_W-1:0] t_reg, t_next;
    logic [ACC_W-1:0]   a_reg, a_next;
    logic [ACC_W-1:0]   e_reg, e_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   d_reg, d_next;
    logic [COLOR_W-1:0] q_reg, q_next;
    logic [EL_W-1:0]    rest;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        s_next    = s_reg;
        t_next    = t_reg;
        a_next    = a_reg;
        e_next    = e_reg;
        acc_next  = acc_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        rest      = {1'b0, req.dur} - req.el;
        if (req.go)
        begin
            busy_next = 1'b1;
            div_next  = 1'b0;
            cnt_next  = '0;
            s_next    = req.s;
            t_next    = req.t;
            a_next    = ACC_W'(rest);
            e_next    = ACC_W'(req.el);
            acc_next  = '0;
            d_next    = ACC_W'(req.dur) << (COLOR_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = 3'(cnt_reg + 1'b1);
            if (!div_reg)
            begin
                acc_next = acc_reg + (s_reg[0] ? a_reg : '0) + (t_reg[0] ? e_reg : '0);
                s_next   = s_reg >> 1;
                t_next   = t_reg >> 1;
                a_next   = a_reg << 1;
                e_next   = e_reg << 1;
                if (cnt_reg == 3'd7)
                    div_next = 1'b1;
            end
            else
            begin
                if (acc_reg >= d_reg)
                begin
                    acc_next = acc_reg - d_reg;
                    q_next   = {q_reg[COLOR_W-2:0], 1'b1};
                end
                else
                    q_next = {q_reg[COLOR_W-2:0], 1'b0};
                d_next = d_reg >> 1;
                if (cnt_reg == 3'd7)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        t_reg   <= t_next;
        a_reg   <= a_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

FILE: rtl/rgb_led_fade_engine.sv
// Linear RGB fade engine, BOARDS boards of LEDS_PER_BOARD LEDs.
// Input channel (in_valid/in_stall): op 0 sets one LED's target color and
// speed; op 1 is a time tick of elapsed_ms. in_stall is high while an item
// is being worked on; one item is processed at a time.
// Output channel (out_valid/out_stall): whole boards of colors, one LED per
// item in LED order, last set on the board's final LED.
// Set item: at speed 0 the new color is applied at once, else a serial
// divide of 4095 by speed gives the fade duration. A board end with a
// pending snap then sends the whole board. Tick item: per LED, the target
// is taken when its fade is done, else the bit-serial multiply and divide
// of the three channel lanes run; each board with a change or a pending
// snap is then sent.
// A result waits in the output register while out_stall is high; further
// results of the board wait behind it, and the last result may still wait
// while the next item is taken.
// Reset clears all colors, durations, elapsed times and pending flags.
module rgb_led_fade_engine
    import fde_pkg::*;
#(
    parameter int BOARDS         = 2,
    parameter int LEDS_PER_BOARD = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic               board,
    input  logic [2:0]         led,
    input  logic [COLOR_W-1:0] red,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] blue,
    input  logic [7:0]         speed,
    input  logic               last_of_board,
    input  logic [EL_W-1:0]    elapsed_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_board,
    output logic [2:0]         out_led,
    output logic [COLOR_W-1:0] out_red,
    output logic [COLOR_W-1:0] out_green,
    output logic [COLOR_W-1:0] out_blue,
    output logic               last
);

    localparam int NLED = BOARDS * LEDS_PER_BOARD;
    localparam int BW   = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam int LW   = (LEDS_PER_BOARD > 1) ? $clog2(LEDS_PER_BOARD) : 1;
    localparam int IW   = (NLED > 1) ? $clog2(NLED) : 1;
    localparam int RGB_W = 3 * COLOR_W;

    fsm_t state_reg, state_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [LW-1:0]    l_reg, l_next;
    logic             changed_reg, changed_next;
    logic [BOARDS-1:0] force_reg, force_next;
    logic             snap_reg, snap_next;
    logic             emit_set_reg, emit_set_next;
    logic [EL_W-1:0]  dt_reg, dt_next;
    logic [RGB_W-1:0] tgt_in_reg, tgt_in_next;
    logic [7:0]       speed_reg, speed_next;
    logic             lob_reg, lob_next;
    logic [DUR_W-1:0] dur_val_reg, dur_val_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_board_reg, out_board_next;
    logic [2:0]       out_led_reg, out_led_next;
    logic [RGB_W-1:0] out_rgb_reg, out_rgb_next;
    logic             out_last_reg, out_last_next;

    logic [RGB_W-1:0] start_reg [NLED];
    logic [RGB_W-1:0] tgt_reg   [NLED];
    logic [RGB_W-1:0] cur_reg   [NLED];
    logic [DUR_W-1:0] dur_reg   [NLED];
    logic [EL_W-1:0]  el_reg    [NLED];

    logic [IW-1:0]    idx;
    logic [RGB_W-1:0] cur_rd, tgt_rd, start_rd, newc, cur_wdata;
    logic [DUR_W-1:0] dur_rd;
    logic [EL_W:0]    sum;
    logic [EL_W-1:0]  el_new;
    logic             direct, l_last, b_last, out_free;
    logic             set_wr, el_wr, cur_wr, spd_go, out_load;
    logic             led_fin, board_adv, chg, snap_now;

    logic [SPD_QW-1:0]  spd_q;
    logic               spd_done;
    lerp_req_t          req_r, req_g, req_b;
    logic [COLOR_W-1:0] q_r, q_g, q_b;
    logic               done_r, done_g, done_b;

    assign idx      = IW'(int'(b_reg) * LEDS_PER_BOARD + int'(l_reg));
    assign cur_rd   = cur_reg[idx];
    assign tgt_rd   = tgt_reg[idx];
    assign start_rd = start_reg[idx];
    assign dur_rd   = dur_reg[idx];
    assign sum      = {1'b0, el_reg[idx]} + {1'b0, dt_reg};
    assign el_new   = (sum > (EL_W+1)'(dur_rd)) ? EL_W'(dur_rd) : sum[EL_W-1:0];
    assign direct   = (dur_rd == '0) || (el_new >= EL_W'(dur_rd));
    assign l_last   = (l_reg == LW'(LEDS_PER_BOARD - 1));
    assign b_last   = (b_reg == BW'(BOARDS - 1));
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        req_r.go  = (state_reg == S_LOAD) && !direct;
        req_r.s   = start_rd[RGB_W-1 -: COLOR_W];
        req_r.t   = tgt_rd[RGB_W-1 -: COLOR_W];
        req_r.el  = el_new;
        req_r.dur = dur_rd;
        req_g     = req_r;
        req_g.s   = start_rd[2*COLOR_W-1 -: COLOR_W];
        req_g.t   = tgt_rd[2*COLOR_W-1 -: COLOR_W];
        req_b     = req_r;
        req_b.s   = start_rd[COLOR_W-1:0];
        req_b.t   = tgt_rd[COLOR_W-1:0];
    end

    fde_spd u_spd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (spd_go),
        .speed (speed_reg),
        .quot  (spd_q),
        .done  (spd_done)
    );

    fde_lerp u_lerp_r (.clk(clk), .rst_n(rst_n), .req(req_r), .quot(q_r), .done(done_r));
    fde_lerp u_lerp_g (.clk(clk), .rst_n(rst_n), .req(req_g), .quot(q_g), .done(done_g));
    fde_lerp u_lerp_b (.clk(clk), .rst_n(rst_n), .req(req_b), .quot(q_b), .done(done_b));

    always_comb
    begin
        state_next    = state_reg;
        b_next        = b_reg;
        l_next        = l_reg;
        changed_next  = changed_reg;
        force_next    = force_reg;
        snap_next     = snap_reg;
        emit_set_next = emit_set_reg;
        dt_next       = dt_reg;
        tgt_in_next   = tgt_in_reg;
        speed_next    = speed_reg;
        lob_next      = lob_reg;
        dur_val_next  = dur_val_reg;
        set_wr        = 1'b0;
        el_wr         = 1'b0;
        cur_wr        = 1'b0;
        cur_wdata     = tgt_rd;
        spd_go        = 1'b0;
        out_load      = 1'b0;
        led_fin       = 1'b0;
        board_adv     = 1'b0;
        newc          = tgt_rd;
        chg           = 1'b0;
        snap_now      = snap_reg || (speed_reg == '0);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_TICK)
                    begin
                        dt_next      = elapsed_ms;
                        b_next       = '0;
                        l_next       = '0;
                        changed_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                    else if ((int'(board) < BOARDS) && (int'(led) < LEDS_PER_BOARD))
                    begin
                        b_next      = BW'(board);
                        l_next      = LW'(led);
                        tgt_in_next = {red, green, blue};
                        speed_next  = speed;
                        lob_next    = last_of_board;
                        if (speed == '0)
                        begin
                            dur_val_next = '0;
                            state_next   = S_APPLY;
                        end
                        else
                        begin
                            spd_go     = 1'b1;
                            state_next = S_SPD;
                        end
                    end
                end
            end
            S_SPD:
            begin
                if (spd_done)
                begin
                    dur_val_next = DUR_W'({spd_q, {DUR_SHIFT{1'b0}}});
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                set_wr = 1'b1;
                if (lob_reg)
                begin
                    snap_next = 1'b0;
                    if (snap_now)
                    begin
                        force_next[b_reg] = 1'b1;
                        l_next            = '0;
                        emit_set_next     = 1'b1;
                        state_next        = S_EMIT;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    snap_next  = snap_now;
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                el_wr = 1'b1;
                if (direct)
                begin
                    newc    = tgt_rd;
                    led_fin = 1'b1;
                end
                else
                    state_next = S_LERP;
            end
            S_LERP:
            begin
                if (done_r && done_g && done_b)
                begin
                    newc    = {q_r, q_g, q_b};
                    led_fin = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (l_last)
                    begin
                        if (emit_set_reg)
                            state_next = S_IDLE;
                        else
                            board_adv = 1'b1;
                    end
                    else
                        l_next = LW'(l_reg + 1'b1);
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (led_fin)
        begin
            cur_wr    = 1'b1;
            cur_wdata = newc;
            chg       = changed_reg || (newc != cur_rd);
            if (l_last)
            begin
                if (chg || force_reg[b_reg])
                begin
                    force_next[b_reg] = 1'b0;
                    l_next            = '0;
                    emit_set_next     = 1'b0;
                    state_next        = S_EMIT;
                end
                else
                    board_adv = 1'b1;
            end
            else
            begin
                l_next       = LW'(l_reg + 1'b1);
                changed_next = chg;
                state_next   = S_LOAD;
            end
        end

        if (board_adv)
        begin
            if (b_last)
                state_next = S_IDLE;
            else
            begin
                b_next       = BW'(b_reg + 1'b1);
                l_next       = '0;
                changed_next = 1'b0;
                state_next   = S_LOAD;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_board_next = out_board_reg;
        out_led_next   = out_led_reg;
        out_rgb_next   = out_rgb_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_board_next = 1'(b_reg);
            out_led_next   = 3'(l_reg);
            out_rgb_next   = cur_rd;
            out_last_next  = l_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            b_reg         <= '0;
            l_reg         <= '0;
            changed_reg   <= 1'b0;
            force_reg     <= '0;
            snap_reg      <= 1'b0;
            emit_set_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_reg         <= b_next;
            l_reg         <= l_next;
            changed_reg   <= changed_next;
            force_reg     <= force_next;
            snap_reg      <= snap_next;
            emit_set_reg  <= emit_set_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg        <= dt_next;
        tgt_in_reg    <= tgt_in_next;
        speed_reg     <= speed_next;
        lob_reg       <= lob_next;
        dur_val_reg   <= dur_val_next;
        out_board_reg <= out_board_next;
        out_led_reg   <= out_led_next;
        out_rgb_reg   <= out_rgb_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NLED; i++)
            begin
                start_reg[i] <= '0;
                tgt_reg[i]   <= '0;
                cur_reg[i]   <= '0;
                dur_reg[i]   <= '0;
                el_reg[i]    <= '0;
            end
        end
        else
        begin
            if (set_wr)
            begin
                start_reg[idx] <= cur_rd;
                tgt_reg[idx]   <= tgt_in_reg;
                dur_reg[idx]   <= dur_val_reg;
                el_reg[idx]    <= '0;
                if (speed_reg == '0)
                    cur_reg[idx] <= tgt_in_reg;
            end
            if (el_wr)
                el_reg[idx] <= el_new;
            if (cur_wr)
                cur_reg[idx] <= cur_wdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_board = out_board_reg;
    assign out_led   = out_led_reg;
    assign out_red   = out_rgb_reg[RGB_W-1 -: COLOR_W];
    assign out_green = out_rgb_reg[2*COLOR_W-1 -: COLOR_W];
    assign out_blue  = out_rgb_reg[COLOR_W-1:0];
    assign last      = out_last_reg;

endmodule

FILE: rtl/fde_chk.sv
`include "rgb_led_fade_engine_defines.svh"

module fde_chk
    import fde_pkg::*;
#(
    parameter int LEDS_PER_BOARD = 8
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] out_led,
    input logic       last
);

    `FDE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_led), "stalled item changed")
    `FDE_ASSERT_NOW(a_busy_mid_board, out_valid && !last, in_stall, "input taken mid board")
    `FDE_ASSERT_NOW(a_last_led, out_valid && last, out_led == 3'(LEDS_PER_BOARD - 1), "last on wrong LED")
    `FDE_ASSERT_NEXT(a_board_cont, out_valid && !out_stall && !last, out_valid, "gap inside a board")

endmodule

bind rgb_led_fade_engine fde_chk #(.LEDS_PER_BOARD(LEDS_PER_BOARD)) u_fde_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_led   (out_led),
    .last      (last)
);

FILE: tb/sv/tb_top.sv
module tb_top;
    import fde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 2;
    localparam int NL = 8;

    typedef struct packed {
        logic       brd;
        logic [2:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       lst;
    } led_color_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = OP_SET;
    logic               board = 1'b0;
    logic [2:0]         led = '0;
    logic [COLOR_W-1:0] red = '0;
    logic [COLOR_W-1:0] green = '0;
    logic [COLOR_W-1:0] blue = '0;
    logic [7:0]         speed = '0;
    logic               last_of_board = 1'b0;
    logic [EL_W-1:0]    elapsed_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               out_board;
    logic [2:0]         out_led;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               last;

    // fade state mirror
    logic [7:0]  st_r [NB][NL], st_g [NB][NL], st_b [NB][NL];
    logic [7:0]  tg_r [NB][NL], tg_g [NB][NL], tg_b [NB][NL];
    logic [7:0]  cu_r [NB][NL], cu_g [NB][NL], cu_b [NB][NL];
    int unsigned dur_ms [NB][NL];
    int unsigned el_ms [NB][NL];
    bit          resend [NB];
    bit          snap_pend;

    led_color_t expected_colors[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  colors_seen = 0;
    int  sink_hold = 0;
    bit  sink_quiet = 1'b0;
    bit  src_quiet = 1'b0;

    rgb_led_fade_engine u_dut (.*);

    always #4 clk = ~clk;

    function automatic logic [7:0] lerp8(logic [7:0] s, logic [7:0] t, int unsigned el,
                                         int unsigned dur);
        longint num;
        num = longint'(s) * dur + (longint'(t) - longint'(s)) * el;
        if (num < 0)
            num = 0;
        return 8'(num / dur);
    endfunction

    function automatic void queue_board(int b);
        led_color_t c;
        for (int i = 0; i < NL; i++)
        begin
            c.brd = 1'(b);
            c.idx = 3'(i);
            c.r   = cu_r[b][i];
            c.g   = cu_g[b][i];
            c.b   = cu_b[b][i];
            c.lst = (i == NL - 1);
            expected_colors.push_back(c);
        end
    endfunction

    function automatic void fade_predict(logic o, logic b, logic [2:0] l, logic [7:0] r,
                                         logic [7:0] g, logic [7:0] bl, logic [7:0] sp,
                                         logic lst, logic [15:0] dt);
        int unsigned el;
        int unsigned d;
        logic [7:0] nr, ng, nb;
        bit changed;
        if (o == OP_SET)
        begin
            st_r[b][l] = cu_r[b][l];
            st_g[b][l] = cu_g[b][l];
            st_b[b][l] = cu_b[b][l];
            tg_r[b][l] = r;
            tg_g[b][l] = g;
            tg_b[b][l] = bl;
            el_ms[b][l] = 0;
            if (sp == 0)
            begin
                dur_ms[b][l] = 0;
                cu_r[b][l] = r;
                cu_g[b][l] = g;
                cu_b[b][l] = bl;
                snap_pend = 1'b1;
            end
            else
                dur_ms[b][l] = (4095 / sp) * 8;
            if (lst)
            begin
                if (snap_pend)
                begin
                    resend[b] = 1'b1;
                    queue_board(b);
                end
                snap_pend = 1'b0;
            end
            return;
        end
        for (int bb = 0; bb < NB; bb++)
        begin
            changed = 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                d = dur_ms[bb][i];
                el = el_ms[bb][i] + dt;
                if (el > d)
                    el = d;
                el_ms[bb][i] = el;
                if (d == 0 || el >= d)
                begin
                    nr = tg_r[bb][i];
                    ng = tg_g[bb][i];
                    nb = tg_b[bb][i];
                end
                else
                begin
                    nr = lerp8(st_r[bb][i], tg_r[bb][i], el, d);
                    ng = lerp8(st_g[bb][i], tg_g[bb][i], el, d);
                    nb = lerp8(st_b[bb][i], tg_b[bb][i], el, d);
                end
                if (nr != cu_r[bb][i] || ng != cu_g[bb][i] || nb != cu_b[bb][i])
                    changed = 1'b1;
                cu_r[bb][i] = nr;
                cu_g[bb][i] = ng;
                cu_b[bb][i] = nb;
            end
            if (changed || resend[bb])
            begin
                queue_board(bb);
                resend[bb] = 1'b0;
            end
        end
    endfunction

    task automatic send_item(logic o, logic b, logic [2:0] l, logic [7:0] r, logic [7:0] g,
                             logic [7:0] bl, logic [7:0] sp, logic lst, logic [15:0] dt);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op            <= o;
        board         <= b;
        led           <= l;
        red           <= r;
        green         <= g;
        blue          <= bl;
        speed         <= sp;
        last_of_board <= lst;
        elapsed_ms    <= dt;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        fade_predict(o, b, l, r, g, bl, sp, lst, dt);
        items_sent++;
    endtask

    // unused fields carry random junk
    task automatic send_set(logic b, logic [2:0] l, logic [7:0] r, logic [7:0] g,
                            logic [7:0] bl, logic [7:0] sp, logic lst);
        send_item(OP_SET, b, l, r, g, bl, sp, lst, 16'($urandom));
    endtask

    task automatic send_tick(logic [15:0] dt);
        send_item(OP_TICK, 1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'($urandom), dt);
    endtask

    task automatic send_board_update(logic b, int zero_pct);
        logic [7:0] sp;
        for (int i = 0; i < NL; i++)
        begin
            sp = ($urandom_range(0, 99) < zero_pct) ? 8'd0 : 8'($urandom_range(1, 255));
            if ($urandom_range(0, 3) == 0)
                sp = 8'($urandom_range(128, 255));
            send_set(b, 3'(i), 8'($urandom), 8'($urandom), 8'($urandom), sp, i == NL - 1);
        end
    endtask

    task automatic test_directed();
        send_tick(16'd0);
        for (int i = 0; i < NL; i++)
            send_set(1'b0, 3'(i), 8'hff, 8'h00, 8'hff, 8'd0, i == NL - 1);
        send_tick(16'd0);
        send_set(1'b1, 3'd7, 8'hff, 8'hff, 8'hff, 8'd255, 1'b1);
        send_set(1'b0, 3'd0, 8'h00, 8'hff, 8'h00, 8'd1, 1'b0);
        send_set(1'b0, 3'd3, 8'h80, 8'h7f, 8'h01, 8'd0, 1'b0);
        send_set(1'b0, 3'd5, 8'h55, 8'haa, 8'h33, 8'd17, 1'b1);
        send_tick(16'd1);
        send_tick(16'd100);
        send_tick(16'd65535);
        send_tick(16'd65535);
        send_set(1'b1, 3'd2, 8'h00, 8'h00, 8'h00, 8'd128, 1'b0);
        send_set(1'b1, 3'd2, 8'h12, 8'h34, 8'h56, 8'd0, 1'b0);
        send_set(1'b1, 3'd4, 8'hff, 8'h00, 8'h80, 8'd2, 1'b1);
        send_tick(16'd16380);
        send_tick(16'd32);
    endtask

    task automatic test_random_traffic();
        int k;
        repeat (32)
        begin
            k = $urandom_range(0, 9);
            sink_quiet = ($urandom_range(0, 7) == 0);
            src_quiet  = ($urandom_range(0, 7) == 0);
            if (k < 4)
                send_tick(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 3000)));
            else if (k < 5)
                send_board_update(1'($urandom), 40);
            else
                send_set(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom),
                         ($urandom_range(0, 3) == 0));
        end
        sink_quiet = 1'b0;
        src_quiet  = 1'b0;
    endtask

    task automatic test_output_backpressure();
        sink_hold  = 600;
        src_quiet  = 1'b1;
        send_board_update(1'b0, 100);
        send_board_update(1'b1, 100);
        send_tick(16'd0);
        send_board_update(1'b0, 50);
        send_tick(16'd500);
        src_quiet  = 1'b0;
    endtask

    // result sink
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                n = sink_hold;
                sink_hold = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            n = sink_quiet ? 0 : $urandom_range(0, 17);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        led_color_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            colors_seen++;
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color: board %0d led %0d rgb %h%h%h last %b",
                             out_board, out_led, out_red, out_green, out_blue, last);
            end
            else
            begin
                e = expected_colors.pop_front();
                if (out_board !== e.brd || out_led !== e.idx || out_red !== e.r ||
                    out_green !== e.g || out_blue !== e.b || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp b%0d l%0d %h%h%h %b, got b%0d l%0d %h%h%h %b",
                                 e.brd, e.idx, e.r, e.g, e.b, e.lst, out_board, out_led,
                                 out_red, out_green, out_blue, last);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        for (int b = 0; b < NB; b++)
        begin
            resend[b] = 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                st_r[b][i] = '0; st_g[b][i] = '0; st_b[b][i] = '0;
                tg_r[b][i] = '0; tg_g[b][i] = '0; tg_b[b][i] = '0;
                cu_r[b][i] = '0; cu_g[b][i] = '0; cu_b[b][i] = '0;
                dur_ms[b][i] = 0;
                el_ms[b][i] = 0;
            end
        end
        snap_pend = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_random_traffic();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_colors.size() == 0);
        repeat (400) @(posedge clk);
        if (expected_colors.size() != 0)
            mismatches++;
        $display("Sent %0d set/tick items (snaps, fades, saturating ticks, long output hold);",
                 items_sent);
        $display("checked %0d LED colors, %0d mismatches.", colors_seen, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
